/* design/dram_address_field_decode_defines.svh */
// Assertion macros shared by the checker of the DRAM address field decoder.
// Include once; no dependencies.
`ifndef DRAM_ADDRESS_FIELD_DECODE_DEFINES_SVH
`define DRAM_ADDRESS_FIELD_DECODE_DEFINES_SVH

// Implication in the same cycle, ignored during reset
`define DAFD_AST_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dafd check failed");

// Implication in the next cycle, ignored during reset
`define DAFD_AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dafd check failed");

// Implication in the next cycle, checked through reset as well
`define DAFD_AST_NEXT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("dafd reset check failed");

`endif

/* design/dafd_pkg.sv */
// Shared types, constants and digit order tables for the DRAM address decoder.
// No dependencies.
`timescale 1ns / 1ps

package dafd_pkg;

    localparam int ADDR_W         = 64;
    localparam int DIV_W          = 21;
    localparam int BITS_PER_STAGE = 4;
    localparam int DIV_STAGES     = ADDR_W / BITS_PER_STAGE;
    localparam int NUM_DIGITS     = 8;
    localparam int NUM_DIVS       = NUM_DIGITS + 1;
    localparam int SIDE_W         = NUM_DIGITS * DIV_W;
    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = 21;

    localparam int DEF_PCH_COUNT = 2;
    localparam int DEF_STACK_IDS = 4;

    typedef enum logic [2:0] {
        DIM_COL, DIM_ROW, DIM_BANK, DIM_BG, DIM_PC, DIM_SID, DIM_RANK, DIM_CHAN
    } t_dim;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE  = 4'd0,
        REG_LINE  = 4'd1,
        REG_COL   = 4'd2,
        REG_ROW   = 4'd3,
        REG_BANK  = 4'd4,
        REG_BG    = 4'd5,
        REG_RANK  = 4'd6,
        REG_CHAN  = 4'd7
    } t_reg_idx;

    // Effective dimension sizes, already saturated and with zero read as one
    typedef struct packed {
        logic [2:0]       mode;
        logic [DIV_W-1:0] line;
        logic [DIV_W-1:0] col;
        logic [DIV_W-1:0] row;
        logic [DIV_W-1:0] bank;
        logic [DIV_W-1:0] bg;
        logic [DIV_W-1:0] rank;
        logic [DIV_W-1:0] chan;
    } t_sizes;

    // Dimension taken at digit position pos, least significant first
    function automatic t_dim dim_at(input logic [1:0] mode, input logic [2:0] pos);
        t_dim d;
        d = DIM_COL;
        unique case (mode)
            2'd0: begin
                unique case (pos)
                    3'd0: d = DIM_COL;
                    3'd1: d = DIM_BANK;
                    3'd2: d = DIM_BG;
                    3'd3: d = DIM_PC;
                    3'd4: d = DIM_SID;
                    3'd5: d = DIM_RANK;
                    3'd6: d = DIM_CHAN;
                    default: d = DIM_ROW;
                endcase
            end
            2'd1: begin
                unique case (pos)
                    3'd0: d = DIM_CHAN;
                    3'd1: d = DIM_COL;
                    3'd2: d = DIM_RANK;
                    3'd3: d = DIM_BANK;
                    3'd4: d = DIM_BG;
                    3'd5: d = DIM_PC;
                    3'd6: d = DIM_SID;
                    default: d = DIM_ROW;
                endcase
            end
            2'd2: begin
                unique case (pos)
                    3'd0: d = DIM_COL;
                    3'd1: d = DIM_ROW;
                    3'd2: d = DIM_BANK;
                    3'd3: d = DIM_BG;
                    3'd4: d = DIM_PC;
                    3'd5: d = DIM_SID;
                    3'd6: d = DIM_RANK;
                    default: d = DIM_CHAN;
                endcase
            end
            default: begin
                unique case (pos)
                    3'd0: d = DIM_CHAN;
                    3'd1: d = DIM_BANK;
                    3'd2: d = DIM_BG;
                    3'd3: d = DIM_PC;
                    3'd4: d = DIM_SID;
                    3'd5: d = DIM_RANK;
                    3'd6: d = DIM_COL;
                    default: d = DIM_ROW;
                endcase
            end
        endcase
        return d;
    endfunction

    // Digit position that holds dimension d
    function automatic logic [2:0] pos_of(input logic [1:0] mode, input t_dim d);
        logic [2:0] p;
        p = 3'd0;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (dim_at(mode, 3'(k)) == d) begin
                p = 3'(k);
            end
        end
        return p;
    endfunction

endpackage

/* design/dram_address_field_decode.sv */
// DRAM address field decoder top level: line division and mixed-radix digits.
// Depends on dafd_pkg, dafd_cfg and dafd_div.
//
// Usage:
//  - Input channel i_in_valid / o_in_ready carries i_byte_address. Output
//    channel o_out_valid / i_out_ready carries the decoded column, row, bank,
//    bank group, pseudo-channel, stack id, rank and channel.
//  - Configuration channel i_cfg_valid / o_cfg_ready writes register
//    i_cfg_index with i_cfg_data; always ready. Write only while no
//    transaction is in flight; indexes above 7 are ignored.
//  - The datapath is nine chained dividers (line size, then eight
//    digits) of 16 stages each, 4 quotient bits per stage, plus the output
//    register. Throughput is one transaction per cycle unless a held result stalls.
//  - Reset clears all stage valid bits and loads the register defaults.
//  - When the receiver stalls a held result, the whole pipeline freezes and
//    o_in_ready falls; nothing is lost or repeated. Bubbles move on while
//    the output register is empty or being taken.
`timescale 1ns / 1ps

module dram_address_field_decode
    import dafd_pkg::*;
#(
    parameter int PCH_COUNT = DEF_PCH_COUNT,
    parameter int STACK_IDS = DEF_STACK_IDS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [ADDR_W-1:0]     i_byte_address,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [5:0]            o_channel,
    output logic [2:0]            o_rank,
    output logic [3:0]            o_bgrp,
    output logic [3:0]            o_bank,
    output logic [0:0]            o_pchan,
    output logic [1:0]            o_stack,
    output logic [19:0]           o_row,
    output logic [11:0]           o_column
);

    t_sizes            sizes;
    logic              en;
    logic              v_in  [NUM_DIVS];
    logic [ADDR_W-1:0] d_in  [NUM_DIVS];
    logic [DIV_W-1:0]  dv    [NUM_DIVS];
    logic [SIDE_W-1:0] s_in  [NUM_DIVS];
    logic              v_out [NUM_DIVS];
    logic [ADDR_W-1:0] q_out [NUM_DIVS];
    logic [DIV_W-1:0]  r_out [NUM_DIVS];
    logic [SIDE_W-1:0] s_out [NUM_DIVS];
    logic [SIDE_W-1:0] fin;

    logic        r_out_valid;
    logic [5:0]  r_channel;
    logic [2:0]  r_rank;
    logic [3:0]  r_bgrp;
    logic [3:0]  r_bank;
    logic [0:0]  r_pc;
    logic [1:0]  r_sid;
    logic [19:0] r_row;
    logic [11:0] r_column;

    function automatic logic [DIV_W-1:0] dim_size(input t_sizes sz, input t_dim d);
        logic [DIV_W-1:0] v;
        v = DIV_W'(1);
        unique case (d)
            DIM_COL:  v = sz.col;
            DIM_ROW:  v = sz.row;
            DIM_BANK: v = sz.bank;
            DIM_BG:   v = sz.bg;
            DIM_PC:   v = DIV_W'(PCH_COUNT);
            DIM_SID:  v = DIV_W'(STACK_IDS);
            DIM_RANK: v = sz.rank;
            DIM_CHAN: v = sz.chan;
            default:  v = DIV_W'(1);
        endcase
        return v;
    endfunction

    dafd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_sizes     (sizes)
    );

    assign o_cfg_ready = 1'b1;

    // Advance everything unless a held result is stalled
    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    // Chain the dividers; each digit divider passes its remainder into the digit word
    always_comb begin
        for (int k = 0; k < NUM_DIVS; k++) begin
            if (k == 0) begin
                v_in[k] = i_in_valid;
                d_in[k] = i_byte_address;
                dv[k]   = sizes.line;
                s_in[k] = '0;
            end else begin
                v_in[k] = v_out[k-1];
                d_in[k] = q_out[k-1];
                dv[k]   = dim_size(sizes, dim_at(sizes.mode[1:0], 3'(k-1)));
                s_in[k] = s_out[k-1];
                if (k >= 2) begin
                    s_in[k][(k-2)*DIV_W +: DIV_W] = r_out[k-1];
                end
            end
        end
        fin = s_out[NUM_DIVS-1];
        fin[(NUM_DIGITS-1)*DIV_W +: DIV_W] = r_out[NUM_DIVS-1];
    end

    for (genvar k = 0; k < NUM_DIVS; k++) begin : g_div
        dafd_div u_div (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (en),
            .i_valid     (v_in[k]),
            .i_dividend  (d_in[k]),
            .i_divisor   (dv[k]),
            .i_side      (s_in[k]),
            .o_valid     (v_out[k]),
            .o_quotient  (q_out[k]),
            .o_remainder (r_out[k]),
            .o_side      (s_out[k])
        );
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= v_out[NUM_DIVS-1];
        end
    end

    // Route digits to fields by digit order
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_column  <= fin[32'(pos_of(sizes.mode[1:0], DIM_COL))  * DIV_W +: 12];
            r_row     <= fin[32'(pos_of(sizes.mode[1:0], DIM_ROW))  * DIV_W +: 20];
            r_bank    <= fin[32'(pos_of(sizes.mode[1:0], DIM_BANK)) * DIV_W +: 4];
            r_bgrp    <= fin[32'(pos_of(sizes.mode[1:0], DIM_BG))   * DIV_W +: 4];
            r_sid     <= fin[32'(pos_of(sizes.mode[1:0], DIM_SID))  * DIV_W +: 2];
            r_rank    <= fin[32'(pos_of(sizes.mode[1:0], DIM_RANK)) * DIV_W +: 3];
            r_channel <= fin[32'(pos_of(sizes.mode[1:0], DIM_CHAN)) * DIV_W +: 6];
            r_pc      <= sizes.mode[2] ? 1'b0
                       : fin[32'(pos_of(sizes.mode[1:0], DIM_PC)) * DIV_W +: 1];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_channel   = r_channel;
    assign o_rank      = r_rank;
    assign o_bgrp      = r_bgrp;
    assign o_bank      = r_bank;
    assign o_pchan     = r_pc;
    assign o_stack     = r_sid;
    assign o_row       = r_row;
    assign o_column    = r_column;

endmodule

/* design/dafd_cfg.sv */
// Configuration register file; presents effective dimension sizes.
// Depends on dafd_pkg.
`timescale 1ns / 1ps

module dafd_cfg
    import dafd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_sizes                o_sizes
);

    logic [2:0]  r_mode;
    logic [8:0]  r_line;
    logic [12:0] r_col;
    logic [20:0] r_row;
    logic [4:0]  r_bank;
    logic [4:0]  r_bg;
    logic [3:0]  r_rank;
    logic [6:0]  r_chan;

    // Saturate to the maximum, read zero as one
    function automatic logic [DIV_W-1:0] eff(input logic [DIV_W-1:0] raw,
                                             input logic [DIV_W-1:0] max);
        logic [DIV_W-1:0] v;
        v = (raw > max) ? max : raw;
        return (v == '0) ? DIV_W'(1) : v;
    endfunction

    // Write registers; out-of-range indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 3'd0;
            r_line <= 9'd32;
            r_col  <= 13'd64;
            r_row  <= 21'd16384;
            r_bank <= 5'd4;
            r_bg   <= 5'd4;
            r_rank <= 4'd1;
            r_chan <= 7'd8;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MODE: r_mode <= i_cfg_data[2:0];
                REG_LINE: r_line <= i_cfg_data[8:0];
                REG_COL:  r_col  <= i_cfg_data[12:0];
                REG_ROW:  r_row  <= i_cfg_data[20:0];
                REG_BANK: r_bank <= i_cfg_data[4:0];
                REG_BG:   r_bg   <= i_cfg_data[4:0];
                REG_RANK: r_rank <= i_cfg_data[3:0];
                REG_CHAN: r_chan <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_sizes.mode = r_mode;
        o_sizes.line = eff(DIV_W'(r_line), DIV_W'(256));
        o_sizes.col  = eff(DIV_W'(r_col),  DIV_W'(4096));
        o_sizes.row  = eff(r_row,          DIV_W'(1048576));
        o_sizes.bank = eff(DIV_W'(r_bank), DIV_W'(16));
        o_sizes.bg   = eff(DIV_W'(r_bg),   DIV_W'(16));
        o_sizes.rank = eff(DIV_W'(r_rank), DIV_W'(8));
        o_sizes.chan = eff(DIV_W'(r_chan), DIV_W'(64));
    end

endmodule

/* design/dafd_div.sv */
// Pipelined restoring divider, BITS_PER_STAGE quotient bits per stage,
// carrying a sideband word alongside. Depends on dafd_pkg.
`timescale 1ns / 1ps

module dafd_div
    import dafd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [ADDR_W-1:0] i_dividend,
    input  logic [DIV_W-1:0]  i_divisor,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [ADDR_W-1:0] o_quotient,
    output logic [DIV_W-1:0]  o_remainder,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_v    [DIV_STAGES];
    logic [ADDR_W-1:0] r_w    [DIV_STAGES];
    logic [DIV_W-1:0]  r_rem  [DIV_STAGES];
    logic [SIDE_W-1:0] r_side [DIV_STAGES];
    logic [ADDR_W-1:0] n_w    [DIV_STAGES];
    logic [DIV_W-1:0]  n_rem  [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        // Shift in dividend bits, subtract divisor where it fits
        always_comb begin
            logic [ADDR_W-1:0] w;
            logic [DIV_W:0]    r2;
            logic [DIV_W-1:0]  rem;
            w   = (s == 0) ? i_dividend : r_w[(s == 0) ? 0 : s-1];
            rem = (s == 0) ? '0 : r_rem[(s == 0) ? 0 : s-1];
            for (int j = 0; j < BITS_PER_STAGE; j++) begin
                r2 = {rem, w[ADDR_W-1]};
                w  = {w[ADDR_W-2:0], 1'b0};
                if (r2 >= {1'b0, i_divisor}) begin
                    r2   = r2 - {1'b0, i_divisor};
                    w[0] = 1'b1;
                end
                rem = r2[DIV_W-1:0];
            end
            n_w[s]   = w;
            n_rem[s] = rem;
        end

        // Advance the stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= (s == 0) ? i_valid : r_v[(s == 0) ? 0 : s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_w[s]    <= n_w[s];
                r_rem[s]  <= n_rem[s];
                r_side[s] <= (s == 0) ? i_side : r_side[(s == 0) ? 0 : s-1];
            end
        end
    end

    assign o_valid     = r_v[DIV_STAGES-1];
    assign o_quotient  = r_w[DIV_STAGES-1];
    assign o_remainder = r_rem[DIV_STAGES-1];
    assign o_side      = r_side[DIV_STAGES-1];

endmodule

/* design/dafd_checker.sv */
// Port-level checks for the DRAM address field decoder, bound to the top.
// Depends on dafd_pkg and dram_address_field_decode_defines.svh.
`timescale 1ns / 1ps
`include "dram_address_field_decode_defines.svh"

module dafd_checker
    import dafd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [19:0] o_row,
    input logic [11:0] o_column
);

    // A stalled result holds
    `DAFD_AST_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
                   o_out_valid && $stable(o_row) && $stable(o_column))

    // Input is taken exactly when the output side can move
    `DAFD_AST_SAME(a_ready, i_clk, i_rst_n, 1'b1, o_in_ready == (!o_out_valid || i_out_ready))

    // Reset empties the pipeline
    `DAFD_AST_NEXT_RST(a_reset, i_clk, !i_rst_n, !o_out_valid)

    // A presented result carries known data
    `DAFD_AST_SAME(a_known, i_clk, i_rst_n, o_out_valid, !$isunknown({o_row, o_column}))

endmodule

bind dram_address_field_decode dafd_checker u_dafd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_row       (o_row),
    .o_column    (o_column)
);
